@@ hdl/wdds_pkg.sv @@
// ----------------------------------------------------------------------------
// wdds_pkg
// shared types, register codes and reset values of the wind-driven sway unit
// ----------------------------------------------------------------------------
`default_nettype none

package wdds_pkg;

    localparam int CfgIdxW = 8;
    localparam int CfgDataW = 24;

    localparam logic [CfgIdxW-1:0] CFG_WIND_GAIN = 8'd0;
    localparam logic [CfgIdxW-1:0] CFG_STIFF_GAIN = 8'd1;
    localparam logic [CfgIdxW-1:0] CFG_DAMPING = 8'd2;
    localparam logic [CfgIdxW-1:0] CFG_WIND_PERIOD = 8'd3;

    localparam logic [23:0] WIND_GAIN_RST = 24'd16777;
    localparam logic [23:0] STIFF_GAIN_RST = 24'd335544;
    localparam logic [15:0] DAMPING_RST = 16'd64881;
    localparam logic [7:0] WIND_PERIOD_RST = 8'd20;

    // magnitude squared of one in q1.14
    localparam logic [47:0] MAG_ONE_SQ = 48'h0000_1000_0000;

    localparam int SqrtSteps = 24;
    localparam int DivSteps = 16;

    typedef struct packed {
        logic skip;
        logic signed [15:0] wind_x;
        logic signed [15:0] wind_y;
        logic signed [15:0] wind_z;
    } t_in;

    typedef struct packed {
        logic signed [15:0] bend_x;
        logic signed [15:0] bend_y;
        logic signed [15:0] bend_z;
        logic signed [15:0] vel_x;
        logic signed [15:0] vel_y;
        logic signed [15:0] vel_z;
    } t_out;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_CAPTURE,
        OP_LATCH,
        OP_PULL,
        OP_REST,
        OP_V1,
        OP_DAMP,
        OP_V2,
        OP_SQ,
        OP_SUM,
        OP_COPY,
        OP_SQRT_INIT,
        OP_SQRT_STEP,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_DIV_DONE
    } t_op;

    typedef struct packed {
        t_op op;
        logic [1:0] k;
        logic sel_vel;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic skip;
        logic over;
        logic out_free;
    } t_stat;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LATCH,
        S_UPD,
        S_SQ,
        S_SUM,
        S_CHECK,
        S_SQRT,
        S_DINIT,
        S_DIV,
        S_DDONE,
        S_NEXT,
        S_OUT
    } t_state;

endpackage

`default_nettype wire

@@ hdl/wdds_ctrl.sv @@
// ----------------------------------------------------------------------------
// wdds_ctrl
// sequencer that steps the sway datapath through one tick
// ----------------------------------------------------------------------------
`default_nettype none

module wdds_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  wire wdds_pkg::t_stat i_stat,
    output wdds_pkg::t_cmd     o_cmd
);
    import wdds_pkg::*;

    t_state r_state, n_state;
    logic [4:0] r_cnt, n_cnt;
    logic [1:0] r_k, n_k;
    logic r_sel, n_sel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt <= '0;
            r_k <= '0;
            r_sel <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt <= n_cnt;
            r_k <= n_k;
            r_sel <= n_sel;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_cnt = r_cnt;
        n_k = r_k;
        n_sel = r_sel;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_LATCH;
                end
            end
            S_LATCH: begin
                n_cnt = '0;
                n_k = '0;
                n_sel = 1'b0;
                n_state = i_stat.skip ? S_OUT : S_UPD;
            end
            S_UPD: begin
                if (r_cnt == 5'd4) begin
                    n_cnt = '0;
                    if (r_k == 2'd2) begin
                        n_k = '0;
                        n_state = S_SQ;
                    end else begin
                        n_k = r_k + 2'd1;
                    end
                end else begin
                    n_cnt = r_cnt + 5'd1;
                end
            end
            S_SQ: begin
                if (r_k == 2'd2) begin
                    n_k = '0;
                    n_state = S_SUM;
                end else begin
                    n_k = r_k + 2'd1;
                end
            end
            S_SUM: n_state = S_CHECK;
            S_CHECK: begin
                n_cnt = '0;
                n_state = i_stat.over ? S_SQRT : S_NEXT;
            end
            S_SQRT: begin
                if (r_cnt == 5'(SqrtSteps - 1)) begin
                    n_cnt = '0;
                    n_k = '0;
                    n_state = S_DINIT;
                end else begin
                    n_cnt = r_cnt + 5'd1;
                end
            end
            S_DINIT: begin
                n_cnt = '0;
                n_state = S_DIV;
            end
            S_DIV: begin
                if (r_cnt == 5'(DivSteps - 1)) begin
                    n_state = S_DDONE;
                end else begin
                    n_cnt = r_cnt + 5'd1;
                end
            end
            S_DDONE: begin
                if (r_k == 2'd2) begin
                    n_state = S_NEXT;
                end else begin
                    n_k = r_k + 2'd1;
                    n_state = S_DINIT;
                end
            end
            S_NEXT: begin
                n_k = '0;
                if (r_sel) begin
                    n_state = S_OUT;
                end else begin
                    n_sel = 1'b1;
                    n_state = S_SQ;
                end
            end
            S_OUT: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // commands
    always_comb begin
        o_cmd.op = OP_NONE;
        o_cmd.k = r_k;
        o_cmd.sel_vel = r_sel;
        o_cmd.load_out = 1'b0;
        o_in_stall = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.op = OP_CAPTURE;
                end
            end
            S_LATCH: begin
                if (!i_stat.skip) begin
                    o_cmd.op = OP_LATCH;
                end
            end
            S_UPD: begin
                case (r_cnt)
                    5'd0: o_cmd.op = OP_PULL;
                    5'd1: o_cmd.op = OP_REST;
                    5'd2: o_cmd.op = OP_V1;
                    5'd3: o_cmd.op = OP_DAMP;
                    default: o_cmd.op = OP_V2;
                endcase
            end
            S_SQ: o_cmd.op = OP_SQ;
            S_SUM: o_cmd.op = OP_SUM;
            S_CHECK: o_cmd.op = i_stat.over ? OP_SQRT_INIT : OP_COPY;
            S_SQRT: o_cmd.op = OP_SQRT_STEP;
            S_DINIT: o_cmd.op = OP_DIV_INIT;
            S_DIV: o_cmd.op = OP_DIV_STEP;
            S_DDONE: o_cmd.op = OP_DIV_DONE;
            S_NEXT: o_cmd.op = OP_NONE;
            S_OUT: o_cmd.load_out = i_stat.out_free;
            default: o_cmd.op = OP_NONE;
        endcase
    end

endmodule

`default_nettype wire

@@ hdl/wdds_dp.sv @@
// ----------------------------------------------------------------------------
// wdds_dp
// sway datapath: state, shared multiplier, root and divide units, output reg
// ----------------------------------------------------------------------------
`default_nettype none

module wdds_dp (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [wdds_pkg::CfgIdxW-1:0]    i_cfg_index,
    input  wire logic [wdds_pkg::CfgDataW-1:0]   i_cfg_data,
    input  wire wdds_pkg::t_in                   i_in_data,
    input  wire wdds_pkg::t_cmd                  i_cmd,
    output wdds_pkg::t_stat                      o_stat,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output wdds_pkg::t_out                       o_out_data
);
    import wdds_pkg::*;

    logic [23:0] r_wind_gain, r_stiff_gain;
    logic [15:0] r_damping;
    logic [7:0] r_wind_period, r_phase;

    t_in r_in;
    logic signed [15:0] r_held [3];
    logic signed [15:0] r_vel [3];
    logic signed [15:0] r_bend [3];
    logic signed [23:0] r_v1 [3];
    logic signed [23:0] r_b1 [3];
    logic signed [23:0] r_v2 [3];

    logic signed [49:0] r_prod, r_acc;
    logic [47:0] r_sum;
    logic [47:0] r_sqn;
    logic [25:0] r_srem;
    logic [23:0] r_root;
    logic [25:0] r_drem;
    logic [15:0] r_dlow;
    logic [15:0] r_quo;
    logic r_out_valid;
    t_out r_out;

    logic signed [24:0] mul_a, mul_b;
    logic signed [49:0] mul_p;
    logic signed [23:0] cval;
    logic signed [51:0] diff;
    logic signed [23:0] delta, v1;
    logic signed [49:0] damp_r;
    logic [8:0] phase_inc;
    logic [7:0] period;
    logic [27:0] sq_rem2, sq_trial;
    logic [23:0] cabs;
    logic [38:0] num;
    logic [25:0] dt, den;
    logic signed [15:0] qs;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wind_gain <= WIND_GAIN_RST;
            r_stiff_gain <= STIFF_GAIN_RST;
            r_damping <= DAMPING_RST;
            r_wind_period <= WIND_PERIOD_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_WIND_GAIN: r_wind_gain <= i_cfg_data;
                CFG_STIFF_GAIN: r_stiff_gain <= i_cfg_data;
                CFG_DAMPING: r_damping <= i_cfg_data[15:0];
                CFG_WIND_PERIOD: r_wind_period <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    assign cval = i_cmd.sel_vel ? r_v2[i_cmd.k] : r_b1[i_cmd.k];

    // shared multiplier operand select
    always_comb begin
        mul_a = 25'(cval);
        mul_b = 25'(cval);
        case (i_cmd.op)
            OP_PULL: begin
                mul_a = 25'(r_held[i_cmd.k]);
                mul_b = $signed({1'b0, r_wind_gain});
            end
            OP_REST: begin
                mul_a = 25'(r_bend[i_cmd.k]);
                mul_b = $signed({1'b0, r_stiff_gain});
            end
            OP_DAMP: begin
                mul_a = 25'(r_v1[i_cmd.k]);
                mul_b = $signed({9'd0, r_damping});
            end
            default: ;
        endcase
    end
    assign mul_p = mul_a * mul_b;

    // pull minus restoring force, rounded half up to q1.14
    assign diff = (52'(r_acc) <<< 6) - 52'(r_prod) + 52'sd8388608;
    assign delta = 24'(diff >>> 24);
    assign v1 = 24'(r_vel[i_cmd.k]) + delta;
    assign damp_r = (r_prod + 50'sd32768) >>> 16;

    assign period = (r_wind_period == 8'd0) ? 8'd1 : r_wind_period;
    assign phase_inc = {1'b0, r_phase} + 9'd1;

    assign sq_rem2 = {r_srem, r_sqn[47:46]};
    assign sq_trial = {2'b00, r_root, 2'b01};

    assign cabs = cval[23] ? 24'(-cval) : 24'(cval);
    assign num = {cabs, 15'd0} + 39'(r_root);
    assign den = {1'b0, r_root, 1'b0};
    assign dt = {r_drem[24:0], r_dlow[15]};
    assign qs = cval[23] ? -$signed(r_quo) : $signed(r_quo);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
            for (int i = 0; i < 3; i++) begin
                r_held[i] <= '0;
                r_vel[i] <= '0;
                r_bend[i] <= '0;
            end
        end else begin
            case (i_cmd.op)
                OP_LATCH: begin
                    if (r_phase == 8'd0) begin
                        r_held[0] <= r_in.wind_x;
                        r_held[1] <= r_in.wind_y;
                        r_held[2] <= r_in.wind_z;
                    end
                    r_phase <= (phase_inc >= {1'b0, period}) ? 8'd0 : phase_inc[7:0];
                end
                OP_COPY: begin
                    for (int i = 0; i < 3; i++) begin
                        if (i_cmd.sel_vel) begin
                            r_vel[i] <= r_v2[i][15:0];
                        end else begin
                            r_bend[i] <= r_b1[i][15:0];
                        end
                    end
                end
                OP_DIV_DONE: begin
                    if (i_cmd.sel_vel) begin
                        r_vel[i_cmd.k] <= qs;
                    end else begin
                        r_bend[i_cmd.k] <= qs;
                    end
                end
                default: ;
            endcase
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_CAPTURE: r_in <= i_in_data;
            OP_PULL: r_prod <= mul_p;
            OP_REST: begin
                r_acc <= r_prod;
                r_prod <= mul_p;
            end
            OP_V1: begin
                r_v1[i_cmd.k] <= v1;
                r_b1[i_cmd.k] <= 24'(r_bend[i_cmd.k]) + v1;
            end
            OP_DAMP: r_prod <= mul_p;
            OP_V2: r_v2[i_cmd.k] <= damp_r[23:0];
            OP_SQ: begin
                r_prod <= mul_p;
                r_sum <= (i_cmd.k == 2'd0) ? 48'd0 : r_sum + r_prod[47:0];
            end
            OP_SUM: r_sum <= r_sum + r_prod[47:0];
            OP_SQRT_INIT: begin
                r_sqn <= r_sum;
                r_srem <= '0;
                r_root <= '0;
            end
            OP_SQRT_STEP: begin
                r_sqn <= {r_sqn[45:0], 2'b00};
                if (sq_rem2 >= sq_trial) begin
                    r_srem <= 26'(sq_rem2 - sq_trial);
                    r_root <= {r_root[22:0], 1'b1};
                end else begin
                    r_srem <= sq_rem2[25:0];
                    r_root <= {r_root[22:0], 1'b0};
                end
            end
            OP_DIV_INIT: begin
                r_drem <= {3'd0, num[38:16]};
                r_dlow <= num[15:0];
                r_quo <= '0;
            end
            OP_DIV_STEP: begin
                r_dlow <= {r_dlow[14:0], 1'b0};
                if (dt >= den) begin
                    r_drem <= dt - den;
                    r_quo <= {r_quo[14:0], 1'b1};
                end else begin
                    r_drem <= dt;
                    r_quo <= {r_quo[14:0], 1'b0};
                end
            end
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out <= '{bend_x: r_bend[0], bend_y: r_bend[1], bend_z: r_bend[2],
                       vel_x: r_vel[0], vel_y: r_vel[1], vel_z: r_vel[2]};
        end
    end

    assign o_stat.skip = r_in.skip;
    assign o_stat.over = (r_sum > MAG_ONE_SQ);
    assign o_stat.out_free = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data = r_out;

endmodule

`default_nettype wire

@@ hdl/wind_driven_damped_sway_unit.sv @@
// ----------------------------------------------------------------------------
// wind_driven_damped_sway_unit
// damped spring sway of a trunk under latched wind, one transaction per tick
// ----------------------------------------------------------------------------
//
//  channel  | valid       | stall       | payload
//  ---------+-------------+-------------+--------------------------------
//  input    | i_in_valid  | o_in_stall  | i_in_data  (skip, wind x/y/z)
//  result   | o_out_valid | i_out_stall | o_out_data (bend x/y/z, vel x/y/z)
//  config   | i_cfg_we    | -           | i_cfg_index, i_cfg_data
//
//  a skipped tick goes from latch straight to output without an update;
//  each renormalised vector adds a square root and three divides,
//  so the worst case is set by the bit-serial root/divider
//  one transaction at a time; the result register lets the next transaction
//  in while a result is still stalled
//  synchronous active-low reset restores the register defaults and zero state
//
`default_nettype none

module wind_driven_damped_sway_unit (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [wdds_pkg::CfgIdxW-1:0]    i_cfg_index,
    input  wire logic [wdds_pkg::CfgDataW-1:0]   i_cfg_data,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire wdds_pkg::t_in                   i_in_data,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output wdds_pkg::t_out                       o_out_data
);
    import wdds_pkg::*;

    // command and status between sequencer and datapath
    t_cmd cmd;
    t_stat stat;

    wdds_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    wdds_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire
